[rtl/core/ptd_pkg.sv]
// package for the point triplet decoder: payload types, class bounds and masks
`default_nettype none

package ptd_pkg;

    // lower class bounds, one per encoding group but the first
    localparam logic [6:0] CLASS_DX1_LO  = 7'd10;
    localparam logic [6:0] CLASS_DXY1_LO = 7'd20;
    localparam logic [6:0] CLASS_DXY2_LO = 7'd84;
    localparam logic [6:0] CLASS_DXY3_LO = 7'd120;
    localparam logic [6:0] CLASS_DXY4_LO = 7'd124;

    // field masks used by the delta encodings
    localparam logic [6:0] CLASS_MASK   = 7'h7f;
    localparam logic [6:0] HIGH_MASK    = 7'd14;
    localparam logic [6:0] DX_MASK      = 7'h30;
    localparam logic [6:0] DY_MASK      = 7'h0c;
    localparam logic [6:0] PAIR_STEP    = 7'd12;
    localparam logic [3:0] NIBBLE_MASK  = 4'h0f;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] data_b0;
        logic [7:0] data_b1;
        logic [7:0] data_b2;
        logic [7:0] data_b3;
        logic [2:0] bytes_available;
        logic       first_point;
    } ptd_point_t;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic               on_curve;
        logic [2:0]         bytes_used;
        logic               truncated;
    } ptd_result_t;

endpackage

`default_nettype wire

[rtl/core/point_triplet_decoder.sv]
// point triplet decoder top level: flag decode, delta build and running coordinates
`default_nettype none

// Decodes one glyph point per transfer: the flag class picks one of six delta
// encodings over up to four data bytes, and the signed deltas are added to
// running 32-bit x and y coordinates that wrap. A point marked first_point
// restarts both coordinates at zero before its delta is added. When
// bytes_available is smaller than the byte count of the class, the result has
// truncated set, zero coordinates, and the running coordinates are left as
// they were (the first_point restart is skipped too). Counts of 5 to 7 are
// taken as enough for every class. Rate: one point per cycle while point_stall
// is low; one input register and one result register hold the stages, and
// the running coordinates update as a point moves from the first into the
// second. point_stall is only raised while the result register is full and
// the consumer stalls it.
module point_triplet_decoder
    import ptd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        point_valid,
    output logic             point_stall,
    input  wire ptd_point_t  point,
    output logic             result_valid,
    input  wire logic        result_stall,
    output ptd_result_t      result
);

    // input stage
    logic        pt_valid_reg;
    ptd_point_t  pt_reg;

    // running coordinates
    logic [31:0] run_x_reg;
    logic [31:0] run_x_next;
    logic [31:0] run_y_reg;
    logic [31:0] run_y_next;

    // result stage
    logic        res_valid_reg;
    ptd_result_t res_reg;
    ptd_result_t res_next;

    logic        res_free;
    logic        advance;

    // decode of the held point
    logic [6:0]  cls;
    logic [6:0]  k;
    logic [1:0]  quot;
    logic [6:0]  rem;
    logic [2:0]  need;
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] base_x;
    logic [31:0] base_y;
    logic        short_data;

    // result register can take a new point when empty or being drained
    assign res_free    = !res_valid_reg || !result_stall;
    assign advance     = pt_valid_reg && res_free;
    assign point_stall = pt_valid_reg && !res_free;

    always_comb
    begin
        cls   = pt_reg.flag_byte[6:0] & CLASS_MASK;
        k     = 7'd0;
        quot  = 2'd0;
        rem   = 7'd0;
        mag_x = 16'd0;
        mag_y = 16'd0;

        if (cls < CLASS_DXY2_LO)
        begin
            need = 3'd1;
        end
        else if (cls < CLASS_DXY3_LO)
        begin
            need = 3'd2;
        end
        else if (cls < CLASS_DXY4_LO)
        begin
            need = 3'd3;
        end
        else
        begin
            need = 3'd4;
        end

        if (cls < CLASS_DX1_LO)
        begin
            // dy only, 1 byte
            mag_y = (16'(cls & HIGH_MASK) << 7) + 16'(pt_reg.data_b0);
        end
        else if (cls < CLASS_DXY1_LO)
        begin
            // dx only, 1 byte
            k     = cls - CLASS_DX1_LO;
            mag_x = (16'(k & HIGH_MASK) << 7) + 16'(pt_reg.data_b0);
        end
        else if (cls < CLASS_DXY2_LO)
        begin
            // both deltas packed in one byte
            k     = cls - CLASS_DXY1_LO;
            mag_x = 16'd1 + 16'(k & DX_MASK) + 16'(pt_reg.data_b0[7:4]);
            mag_y = 16'd1 + (16'(k & DY_MASK) << 2)
                  + 16'(pt_reg.data_b0[3:0] & NIBBLE_MASK);
        end
        else if (cls < CLASS_DXY3_LO)
        begin
            // two bytes, high bits from the class
            k = cls - CLASS_DXY2_LO;
            if (k >= 7'(2 * PAIR_STEP))
            begin
                quot = 2'd2;
                rem  = k - 7'(2 * PAIR_STEP);
            end
            else if (k >= PAIR_STEP)
            begin
                quot = 2'd1;
                rem  = k - PAIR_STEP;
            end
            else
            begin
                quot = 2'd0;
                rem  = k;
            end
            mag_x = 16'd1 + {6'd0, quot, 8'd0} + 16'(pt_reg.data_b0);
            mag_y = 16'd1 + {6'd0, rem[3:2], 8'd0} + 16'(pt_reg.data_b1);
        end
        else if (cls < CLASS_DXY4_LO)
        begin
            // three bytes, 12 bits each
            mag_x = {4'd0, pt_reg.data_b0, pt_reg.data_b1[7:4]};
            mag_y = {4'd0, pt_reg.data_b1[3:0] & NIBBLE_MASK, pt_reg.data_b2};
        end
        else
        begin
            // four bytes, 16 bits each
            mag_x = {pt_reg.data_b0, pt_reg.data_b1};
            mag_y = {pt_reg.data_b2, pt_reg.data_b3};
        end

        // class bit 0 signs dx, bit 1 signs dy; the one-delta groups use bit 0
        if (cls < CLASS_DX1_LO)
        begin
            dx = 32'd0;
            dy = cls[0] ? 32'(mag_y) : 32'd0 - 32'(mag_y);
        end
        else if (cls < CLASS_DXY1_LO)
        begin
            dx = cls[0] ? 32'(mag_x) : 32'd0 - 32'(mag_x);
            dy = 32'd0;
        end
        else
        begin
            dx = cls[0] ? 32'(mag_x) : 32'd0 - 32'(mag_x);
            dy = cls[1] ? 32'(mag_y) : 32'd0 - 32'(mag_y);
        end

        short_data = pt_reg.bytes_available < need;
        base_x     = pt_reg.first_point ? 32'd0 : run_x_reg;
        base_y     = pt_reg.first_point ? 32'd0 : run_y_reg;

        if (short_data)
        begin
            run_x_next = run_x_reg;
            run_y_next = run_y_reg;
        end
        else
        begin
            run_x_next = base_x + dx;
            run_y_next = base_y + dy;
        end

        res_next.x_coord    = short_data ? 32'sd0 : $signed(run_x_next);
        res_next.y_coord    = short_data ? 32'sd0 : $signed(run_y_next);
        res_next.on_curve   = !pt_reg.flag_byte[7];
        res_next.bytes_used = need;
        res_next.truncated  = short_data;
    end

    // control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            run_x_reg     <= 32'd0;
            run_y_reg     <= 32'd0;
        end
        else
        begin
            if (!point_stall)
            begin
                pt_valid_reg <= point_valid;
            end
            if (res_free)
            begin
                res_valid_reg <= pt_valid_reg;
            end
            if (advance)
            begin
                run_x_reg <= run_x_next;
                run_y_reg <= run_y_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (point_valid && !point_stall)
        begin
            pt_reg <= point;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

[rtl/core/ptd_checker.sv]
// port-level checker for the point triplet decoder and its bind
`default_nettype none

module ptd_port_checker
    import ptd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        point_valid,
    input wire logic        point_stall,
    input wire ptd_point_t  point,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire ptd_result_t result
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // input back-pressure only comes from a stalled full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        point_stall |-> result_valid && result_stall)
        else $error("point stalled without output back-pressure");

    // short data gives zero coordinates
    a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.truncated |->
            result.x_coord == 32'sd0 && result.y_coord == 32'sd0)
        else $error("truncated result with nonzero coordinates");

    // byte count is one to four
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.bytes_used != 3'd0 && result.bytes_used <= 3'd4)
        else $error("bytes_used out of range");

endmodule

bind point_triplet_decoder ptd_port_checker u_ptd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

[dv/ptd_checker.sv]
// scoreboard for the point triplet decoder: predicts each point's coordinates and checks the results
module ptd_checker
    import ptd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        point_valid,
    input  logic        point_stall,
    input  ptd_point_t  point,
    input  logic        result_valid,
    input  logic        result_stall,
    input  ptd_result_t result,
    output int          error_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // running pen position, wraps at 32 bits
    logic [31:0] pen_x = '0;
    logic [31:0] pen_y = '0;

    ptd_result_t decoded_points[$];
    int          mismatches = 0;

    function automatic logic [31:0] apply_sign(input logic positive, input logic [31:0] mag);
        return positive ? mag : 32'd0 - mag;
    endfunction

    // decode one point and move the pen, unless the point is short of bytes
    function automatic ptd_result_t decode_point(input ptd_point_t p);
        ptd_result_t r;
        logic [6:0]  cls;
        logic [31:0] k;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic        y_positive;
        cls = p.flag_byte[6:0];
        r = '0;
        r.on_curve   = ~p.flag_byte[7];
        r.bytes_used = (cls < CLASS_DXY2_LO) ? 3'd1 :
                       (cls < CLASS_DXY3_LO) ? 3'd2 :
                       (cls < CLASS_DXY4_LO) ? 3'd3 : 3'd4;
        if (p.bytes_available < r.bytes_used)
        begin
            r.truncated = 1'b1;
            return r;
        end
        y_positive = cls[1];
        if (cls < CLASS_DX1_LO)
        begin
            // vertical only, sign from bit 0
            mag_x      = '0;
            mag_y      = (32'(cls & HIGH_MASK) << 7) + 32'(p.data_b0);
            y_positive = cls[0];
        end
        else if (cls < CLASS_DXY1_LO)
        begin
            mag_x = (32'((cls - CLASS_DX1_LO) & HIGH_MASK) << 7) + 32'(p.data_b0);
            mag_y = '0;
        end
        else if (cls < CLASS_DXY2_LO)
        begin
            k     = 32'(cls - CLASS_DXY1_LO);
            mag_x = 32'd1 + (k & 32'(DX_MASK)) + 32'(p.data_b0[7:4]);
            mag_y = 32'd1 + ((k & 32'(DY_MASK)) << 2) + 32'(p.data_b0[3:0]);
        end
        else if (cls < CLASS_DXY3_LO)
        begin
            k     = 32'(cls - CLASS_DXY2_LO);
            mag_x = 32'd1 + ((k / 32'(PAIR_STEP)) << 8) + 32'(p.data_b0);
            mag_y = 32'd1 + (((k % 32'(PAIR_STEP)) >> 2) << 8) + 32'(p.data_b1);
        end
        else if (cls < CLASS_DXY4_LO)
        begin
            mag_x = (32'(p.data_b0) << 4) + 32'(p.data_b1[7:4]);
            mag_y = (32'(p.data_b1[3:0]) << 8) + 32'(p.data_b2);
        end
        else
        begin
            mag_x = {16'd0, p.data_b0, p.data_b1};
            mag_y = {16'd0, p.data_b2, p.data_b3};
        end
        if (p.first_point)
        begin
            pen_x = '0;
            pen_y = '0;
        end
        pen_x = pen_x + apply_sign(cls[0], mag_x);
        pen_y = pen_y + apply_sign(y_positive, mag_y);
        r.x_coord = pen_x;
        r.y_coord = pen_y;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                     $time, field, want, want, got, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ptd_result_t want;
        if (!rst_n)
        begin
            pen_x = '0;
            pen_y = '0;
            decoded_points.delete();
        end
        else
        begin
            // results first: a point taken at this edge cannot be answered at it
            if (result_valid && !result_stall)
            begin
                if (decoded_points.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result transfer with none outstanding, actual x %0d y %0d",
                             $time, result.x_coord, result.y_coord);
                end
                else
                begin
                    want = decoded_points.pop_front();
                    compare_field("x_coord", want.x_coord, result.x_coord);
                    compare_field("y_coord", want.y_coord, result.y_coord);
                    compare_field("on_curve", 32'(want.on_curve), 32'(result.on_curve));
                    compare_field("bytes_used", 32'(want.bytes_used), 32'(result.bytes_used));
                    compare_field("truncated", 32'(want.truncated), 32'(result.truncated));
                end
            end
            if (point_valid && !point_stall)
                decoded_points.push_back(decode_point(point));
        end
        error_count   <= mismatches;
        pending_count <= decoded_points.size();
    end

endmodule

[dv/tb_point_triplet_decoder.sv]
// testbench top for the point triplet decoder: clock, reset, point stimulus and verdict
module tb_point_triplet_decoder;
    import ptd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // receiver hold-off and no-stall windows, in cycles since time zero
    localparam int HOLD_START   = 120;
    localparam int HOLD_LEN     = 60;
    localparam int STEADY_START = 400;
    localparam int STEADY_LEN   = 200;
    // sender runs without gaps over this span of random points
    localparam int GAPLESS_FIRST = 250;
    localparam int GAPLESS_LAST  = 370;
    localparam int RANDOM_POINTS = 480;
    localparam int IDLE_PCT      = 22;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        point_valid = 1'b0;
    logic        point_stall;
    ptd_point_t  point = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    ptd_result_t result;
    int          error_count;
    int          pending_count;

    point_triplet_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point        (point),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    ptd_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .point_valid   (point_valid),
        .point_stall   (point_stall),
        .point         (point),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic ptd_point_t pack_point(input logic [7:0] flag, input logic [7:0] b0,
                                              input logic [7:0] b1, input logic [7:0] b2,
                                              input logic [7:0] b3, input logic [2:0] avail,
                                              input logic first);
        ptd_point_t p;
        p.flag_byte       = flag;
        p.data_b0         = b0;
        p.data_b1         = b1;
        p.data_b2         = b2;
        p.data_b3         = b3;
        p.bytes_available = avail;
        p.first_point     = first;
        return p;
    endfunction

    // data bytes that a flag class consumes
    function automatic int class_bytes(input logic [6:0] cls);
        return (cls < CLASS_DXY2_LO) ? 1 : (cls < CLASS_DXY3_LO) ? 2 :
               (cls < CLASS_DXY4_LO) ? 3 : 4;
    endfunction

    // mostly glyph-like runs: enough bytes, an occasional glyph start, some short points
    function automatic ptd_point_t random_point();
        ptd_point_t p;
        int         need;
        p.flag_byte = 8'($urandom_range(255));
        p.data_b0   = 8'($urandom_range(255));
        p.data_b1   = 8'($urandom_range(255));
        p.data_b2   = 8'($urandom_range(255));
        p.data_b3   = 8'($urandom_range(255));
        need = class_bytes(p.flag_byte[6:0]);
        if ($urandom_range(99) < 85)
            p.bytes_available = 3'($urandom_range(7, need));
        else
            p.bytes_available = 3'($urandom_range(need - 1, 0));
        p.first_point = ($urandom_range(99) < 8);
        return p;
    endfunction

    // offer one point, optionally after random idle cycles, and hold it until the transfer
    task automatic offer_point(input ptd_point_t p, input bit gapless);
        if (!gapless)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                point_valid <= 1'b0;
                @(posedge clk);
            end
        end
        point       <= p;
        point_valid <= 1'b1;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
    endtask

    // receiver: random stalls, one long hold-off to back the pipe up, one clean stretch
    initial
    begin : consumer
        int cyc;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
                result_stall <= 1'b1;
            else if (cyc >= STEADY_START && cyc < STEADY_START + STEADY_LEN)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // glyph start, smallest vertical step (negative zero)
        offer_point(pack_point(8'd0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 1'b1), 1'b0);
        offer_point(pack_point(8'd1, 8'hff, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0), 1'b0);
        offer_point(pack_point(8'd9, 8'hff, 8'hff, 8'hff, 8'hff, 3'd4, 1'b0), 1'b0);
        // off-curve vertical step
        offer_point(pack_point(8'h88, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0), 1'b0);
        // horizontal-only group edges
        offer_point(pack_point(8'd10, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0), 1'b0);
        offer_point(pack_point(8'd19, 8'hff, 8'h00, 8'h00, 8'h00, 3'd2, 1'b0), 1'b0);
        // one-byte nibble pairs, all four sign combinations
        offer_point(pack_point(8'd20, 8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0), 1'b0);
        offer_point(pack_point(8'd21, 8'h5a, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0), 1'b0);
        offer_point(pack_point(8'd22, 8'ha5, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0), 1'b0);
        offer_point(pack_point(8'd83, 8'hff, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0), 1'b0);
        // two-byte group edges, count above four
        offer_point(pack_point(8'd84, 8'h00, 8'h00, 8'h00, 8'h00, 3'd2, 1'b0), 1'b0);
        offer_point(pack_point(8'd119, 8'hff, 8'hff, 8'h00, 8'h00, 3'd2, 1'b0), 1'b0);
        offer_point(pack_point(8'd97, 8'h3c, 8'hc3, 8'h00, 8'h00, 3'd7, 1'b0), 1'b0);
        // three-byte group
        offer_point(pack_point(8'd120, 8'hff, 8'hff, 8'hff, 8'h00, 3'd3, 1'b0), 1'b0);
        offer_point(pack_point(8'd123, 8'h00, 8'h00, 8'h00, 8'h00, 3'd5, 1'b0), 1'b0);
        // four-byte group, full magnitudes and mixed byte patterns
        offer_point(pack_point(8'hfc, 8'hff, 8'hff, 8'hff, 8'hff, 3'd4, 1'b0), 1'b0);
        offer_point(pack_point(8'd127, 8'hff, 8'hff, 8'hff, 8'hff, 3'd6, 1'b0), 1'b0);
        offer_point(pack_point(8'd125, 8'h12, 8'h34, 8'h56, 8'h78, 3'd4, 1'b0), 1'b0);
        offer_point(pack_point(8'd126, 8'h87, 8'h65, 8'h43, 8'h21, 3'd4, 1'b0), 1'b0);
        // short of bytes: coordinates untouched, glyph start ignored too
        offer_point(pack_point(8'd124, 8'hff, 8'hff, 8'hff, 8'hff, 3'd3, 1'b1), 1'b0);
        offer_point(pack_point(8'd120, 8'hff, 8'hff, 8'hff, 8'hff, 3'd2, 1'b0), 1'b0);
        offer_point(pack_point(8'd84, 8'hff, 8'hff, 8'hff, 8'hff, 3'd1, 1'b1), 1'b0);
        offer_point(pack_point(8'h80, 8'hff, 8'h00, 8'h00, 8'h00, 3'd0, 1'b0), 1'b0);
        // proper glyph start after the short points
        offer_point(pack_point(8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 3'd7, 1'b1), 1'b0);

        for (int i = 0; i < RANDOM_POINTS; i++)
            offer_point(random_point(), (i >= GAPLESS_FIRST && i <= GAPLESS_LAST));
        point_valid <= 1'b0;

        // let the last transfer land in the checker, then drain
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[point_triplet_decoder.f]
rtl/core/ptd_pkg.sv
rtl/core/point_triplet_decoder.sv
rtl/core/ptd_checker.sv
dv/ptd_checker.sv
dv/tb_point_triplet_decoder.sv
